// ===== design/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and character constants for the comment stripper.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_line_end;
        logic       block_open;
        logic       last;
    } result_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== design/ccs_core.sv =====
// ----------------------------------------------------------------------------
// ccs_core
// Scanner state and per-word update; produces up to two result words.
// ----------------------------------------------------------------------------
module ccs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              line_end,
    output logic [1:0]        res_count,
    output ccs_pkg::result_t  res0,
    output ccs_pkg::result_t  res1
);
    import ccs_pkg::*;

    typedef struct packed {
        logic in_block;
        logic block_star_seen;
        logic in_string;
        logic in_char_lit;
        logic escape_pending;
        logic slash_held;
        logic in_line_comment;
        logic line_nonempty;
        logic last_was_space;
    } scan_state_t;

    scan_state_t st_reg, st_next;

    logic       e0_valid, e1_valid;
    logic [7:0] e0_byte, e1_byte;
    logic       eol_res;

    always_comb begin
        st_next  = st_reg;
        e0_valid = 1'b0;
        e1_valid = 1'b0;
        e0_byte  = ch;
        e1_byte  = ch;
        eol_res  = 1'b0;
        if (line_end) begin
            if (st_reg.slash_held && !st_reg.in_block) begin
                e0_valid = 1'b1;
                e0_byte  = CH_SLASH;
            end
            eol_res                 = 1'b1;
            st_next                 = '0;
            st_next.in_block        = st_reg.in_block;
        end else if (st_reg.in_block) begin
            if (ch == CH_SLASH && st_reg.block_star_seen) begin
                st_next.in_block        = 1'b0;
                st_next.block_star_seen = 1'b0;
            end else begin
                st_next.block_star_seen = (ch == CH_STAR);
            end
        end else if (st_reg.in_line_comment) begin
            st_next = st_reg;
        end else if (st_reg.in_string || st_reg.in_char_lit) begin
            e0_valid = 1'b1;
            if (st_reg.escape_pending) begin
                st_next.escape_pending = 1'b0;
            end else if (ch == CH_BACKSLASH) begin
                st_next.escape_pending = 1'b1;
            end else if (st_reg.in_string && ch == CH_DQUOTE) begin
                st_next.in_string = 1'b0;
            end else if (st_reg.in_char_lit && ch == CH_SQUOTE) begin
                st_next.in_char_lit = 1'b0;
            end
        end else if (st_reg.slash_held) begin
            st_next.slash_held = 1'b0;
            if (ch == CH_SLASH) begin
                st_next.in_line_comment = 1'b1;
            end else if (ch == CH_STAR) begin
                if (st_reg.line_nonempty && !st_reg.last_was_space) begin
                    e0_valid = 1'b1;
                    e0_byte  = CH_SPACE;
                end
                st_next.in_block        = 1'b1;
                st_next.block_star_seen = 1'b0;
            end else begin
                e0_valid = 1'b1;
                e0_byte  = CH_SLASH;
                e1_valid = 1'b1;
                if (ch == CH_DQUOTE) begin
                    st_next.in_string = 1'b1;
                end else if (ch == CH_SQUOTE) begin
                    st_next.in_char_lit = 1'b1;
                end
            end
        end else begin
            if (ch == CH_SLASH) begin
                st_next.slash_held = 1'b1;
            end else begin
                e0_valid = 1'b1;
                if (ch == CH_DQUOTE) begin
                    st_next.in_string = 1'b1;
                end else if (ch == CH_SQUOTE) begin
                    st_next.in_char_lit = 1'b1;
                end
            end
        end

        // line tracking follows the last byte emitted
        if (!line_end) begin
            if (e1_valid) begin
                st_next.line_nonempty  = 1'b1;
                st_next.last_was_space = is_ws(e1_byte);
            end else if (e0_valid) begin
                st_next.line_nonempty  = 1'b1;
                st_next.last_was_space = is_ws(e0_byte);
            end
        end
    end

    always_comb begin
        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        if (e0_valid) begin
            res0.out_byte = e0_byte;
            if (e1_valid) begin
                res1.out_byte = e1_byte;
                res1.last     = 1'b1;
                res_count     = 2'd2;
            end else if (eol_res) begin
                res1.is_line_end = 1'b1;
                res1.block_open  = st_reg.in_block;
                res1.last        = 1'b1;
                res_count        = 2'd2;
            end else begin
                res0.last = 1'b1;
                res_count = 2'd1;
            end
        end else if (eol_res) begin
            res0.is_line_end = 1'b1;
            res0.block_open  = st_reg.in_block;
            res0.last        = 1'b1;
            res_count        = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (step) begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== design/ccs_out_queue.sv =====
// ----------------------------------------------------------------------------
// ccs_out_queue
// Small result queue; takes up to two words per cycle, hands out one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module ccs_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  ccs_pkg::result_t  push0,
    input  ccs_pkg::result_t  push1,
    output logic              room2,
    output logic              m_valid,
    input  logic              m_ready,
    output ccs_pkg::result_t  m_word
);
    import ccs_pkg::*;

    result_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 pop;
    logic [QUEUE_AW-1:0]  wr_ptr_p1;

    assign pop       = m_valid && m_ready;
    assign m_valid   = (count_reg != '0);
    assign m_word    = mem_reg[rd_ptr_reg];
    assign room2     = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + QUEUE_AW'(1);

    always_comb begin
        count_next = count_reg + (QUEUE_AW+1)'(push_count) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(push_count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/c_comment_stripper.sv =====
// the results of an accepted word are written into the result queue and offered from there
// throughput: one word per cycle while s_ready is high; a word that gives two results (flushed
//   slash) pushes both at once into a four-entry result queue
// s_ready is high while the queue has room for two results
// reset: synchronous active-low aresetn clears scanner state and empties the queue
// ----------------------------------------------------------------------------
// c_comment_stripper
// Removes C line and block comments from a byte stream, keeping literals.
// ----------------------------------------------------------------------------
module c_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_line_end,
    output logic       m_block_open,
    output logic       m_last
);
    import ccs_pkg::*;

    logic       step;
    logic [1:0] res_count, push_count;
    result_t    res0, res1, m_word;

    assign step       = s_valid && s_ready;
    assign push_count = step ? res_count : 2'd0;

    ccs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .ch        (s_ch),
        .line_end  (s_line_end),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    ccs_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word)
    );

    assign m_out_byte    = m_word.out_byte;
    assign m_is_line_end = m_word.is_line_end;
    assign m_block_open  = m_word.block_open;
    assign m_last        = m_word.last;

endmodule

// ===== tb/c_comment_stripper_tb.sv =====
// ----------------------------------------------------------------------------
// c_comment_stripper_tb
// Drives C-like source text through the comment stripper one word at a time
// and checks every output word against a scanner model kept in the bench.
// Directed lines cover block and line comments, literals with escapes, held
// slashes and the byte extremes. They are followed by random token streams
// and noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module c_comment_stripper_tb;
    import ccs_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int RANDOM_WORDS = 800;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch       = 8'h00;
    logic       s_line_end = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_is_line_end;
    logic       m_block_open;
    logic       m_last;

    int words_sent  = 0;
    int fail_count  = 0;
    int cycle_count = 0;
    int rx_wait     = 0;
    bit calm        = 1'b0;

    // scanner state of the bench model
    logic in_cmt     = 1'b0;
    logic cmt_star   = 1'b0;
    logic in_str     = 1'b0;
    logic in_chr     = 1'b0;
    logic esc        = 1'b0;
    logic slash_wait = 1'b0;
    logic in_lcmt    = 1'b0;
    logic has_text   = 1'b0;
    logic ends_ws    = 1'b0;

    result_t stripped_q[$];
    result_t word_q[$];

    c_comment_stripper u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_line_end    (s_line_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_is_line_end (m_is_line_end),
        .m_block_open  (m_block_open),
        .m_last        (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic space_byte(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    task automatic keep_byte(input logic [7:0] b);
        result_t r;
        r = '{out_byte: b, is_line_end: 1'b0, block_open: 1'b0, last: 1'b0};
        word_q = {word_q, r};
        has_text = 1'b1;
        ends_ws  = space_byte(b);
    endtask

    task automatic text_byte(input logic [7:0] c);
        if (c == CH_SLASH) begin
            slash_wait = 1'b1;
        end else begin
            keep_byte(c);
            if (c == CH_DQUOTE) begin
                in_str = 1'b1;
            end else if (c == CH_SQUOTE) begin
                in_chr = 1'b1;
            end
        end
    endtask

    task automatic strip_predict(input logic [7:0] c, input logic eol);
        result_t r;
        word_q.delete();
        if (eol) begin
            if (slash_wait && !in_cmt) keep_byte(CH_SLASH);
            r = '{out_byte: 8'h00, is_line_end: 1'b1, block_open: in_cmt, last: 1'b0};
            word_q = {word_q, r};
            cmt_star   = 1'b0;
            in_str     = 1'b0;
            in_chr     = 1'b0;
            esc        = 1'b0;
            slash_wait = 1'b0;
            in_lcmt    = 1'b0;
            has_text   = 1'b0;
            ends_ws    = 1'b0;
        end else if (in_cmt) begin
            if (c == CH_SLASH && cmt_star) begin
                in_cmt   = 1'b0;
                cmt_star = 1'b0;
            end else begin
                cmt_star = (c == CH_STAR);
            end
        end else if (in_lcmt) begin
            // dropped
        end else if (in_str || in_chr) begin
            keep_byte(c);
            if (esc) begin
                esc = 1'b0;
            end else if (c == CH_BACKSLASH) begin
                esc = 1'b1;
            end else if (in_str && c == CH_DQUOTE) begin
                in_str = 1'b0;
            end else if (in_chr && c == CH_SQUOTE) begin
                in_chr = 1'b0;
            end
        end else if (slash_wait) begin
            slash_wait = 1'b0;
            if (c == CH_SLASH) begin
                in_lcmt = 1'b1;
            end else if (c == CH_STAR) begin
                if (has_text && !ends_ws) keep_byte(CH_SPACE);
                in_cmt   = 1'b1;
                cmt_star = 1'b0;
            end else begin
                keep_byte(CH_SLASH);
                text_byte(c);
            end
        end else begin
            text_byte(c);
        end
        if (word_q.size() > 0) word_q[word_q.size() - 1].last = 1'b1;
        foreach (word_q[i]) stripped_q = {stripped_q, word_q[i]};
    endtask

    task automatic send_word(input logic [7:0] c, input logic eol);
        int gap;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_ch       <= c;
        s_line_end <= eol;
        do @(posedge aclk); while (!s_ready);
        strip_predict(c, eol);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_eol();
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (stripped_q.size() != 0) @(posedge aclk);
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (calm) begin
            m_ready <= 1'b1;
        end else if (rx_wait > 0) begin
            m_ready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_ready <= 1'b1;
            rx_wait <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stripped_q.size() == 0) begin
                $error("unexpected word: out_byte %02h is_line_end %0b", m_out_byte,
                       m_is_line_end);
                fail_count++;
            end else begin
                want = stripped_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_is_line_end !== want.is_line_end) begin
                    $error("is_line_end: expected %0b, got %0b", want.is_line_end,
                           m_is_line_end);
                    fail_count++;
                end
                if (m_block_open !== want.block_open) begin
                    $error("block_open: expected %0b, got %0b", want.block_open,
                           m_block_open);
                    fail_count++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_block_comments();
        send_word(8'h61, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_eol();
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_eol();
    endtask

    task automatic test_literals();
        send_word(CH_DQUOTE, 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_DQUOTE, 1'b0);
        send_word(CH_DQUOTE, 1'b0);
        send_word(CH_SQUOTE, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_eol();
    endtask

    task automatic test_slash_handling();
        send_word(8'hFF, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(8'h41, 1'b0);
        send_eol();
        send_word(CH_SLASH, 1'b0);
        send_eol();
    endtask

    function automatic logic [7:0] literal_byte();
        int r;
        r = $urandom_range(0, 19);
        if (r < 5) return CH_BACKSLASH;
        if (r < 7) return CH_DQUOTE;
        if (r < 9) return CH_SQUOTE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_token();
        int kind;
        int n;
        int r;
        logic [7:0] q;
        kind = $urandom_range(0, 10);
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 5);
                repeat (n) send_word(8'($urandom_range(8'h30, 8'h7A)), 1'b0);
            end
            2: begin
                if ($urandom_range(0, 1)) send_word(CH_SPACE, 1'b0);
                else send_word(CH_TAB + 8'($urandom_range(0, 4)), 1'b0);
            end
            3, 4: begin
                q = (kind == 3) ? CH_DQUOTE : CH_SQUOTE;
                send_word(q, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) send_word(literal_byte(), 1'b0);
                if ($urandom_range(0, 4) == 0) send_eol();
                else send_word(q, 1'b0);
            end
            5: begin
                send_word(CH_SLASH, 1'b0);
                send_word(CH_SLASH, 1'b0);
                n = $urandom_range(0, 5);
                repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_eol();
            end
            6: begin
                send_word(CH_SLASH, 1'b0);
                send_word(CH_STAR, 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    r = $urandom_range(0, 9);
                    if (r < 3) send_word(CH_STAR, 1'b0);
                    else if (r < 4) send_word(CH_SLASH, 1'b0);
                    else if (r < 5) send_eol();
                    else send_word(8'($urandom_range(0, 255)), 1'b0);
                end
                if ($urandom_range(0, 3) == 0) begin
                    // star right before a line end leaves the block open on the next line
                    send_word(CH_STAR, 1'b0);
                    send_eol();
                end
                send_word(CH_STAR, 1'b0);
                send_word(CH_SLASH, 1'b0);
            end
            7: begin
                send_word(CH_SLASH, 1'b0);
                if ($urandom_range(0, 3) == 0) send_eol();
                else send_word(8'($urandom_range(0, 255)), 1'b0);
            end
            8: send_eol();
            9: send_word(CH_STAR, 1'b0);
            default: send_word(CH_BACKSLASH, 1'b0);
        endcase
    endtask

    task automatic test_random_source();
        int stop_at;
        int next_drain;
        int next_mode;
        stop_at    = words_sent + RANDOM_WORDS;
        next_drain = words_sent + 200;
        next_mode  = words_sent + 100;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 99) < 85) begin
                send_token();
            end else begin
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
            if (words_sent >= next_mode) begin
                calm      = ($urandom_range(0, 3) == 0);
                next_mode = words_sent + $urandom_range(50, 150);
            end
            if (words_sent >= next_drain) begin
                wait_drained();
                next_drain = words_sent + 200;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_block_comments();
        test_literals();
        test_slash_handling();
        test_random_source();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && stripped_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
